// File: rtl/rre_pkg.sv
// ----------------------------------------------------------------------------
// rre_pkg
// Widths, constants and shared types of the RTT / RTO estimator.
// ----------------------------------------------------------------------------
package rre_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned SrttW   = 20;
  localparam int unsigned DevW    = 21;
  localparam int unsigned RtoW    = 22;

  localparam logic [SampleW-1:0] MinRtoReset = 16'd200;

  typedef struct packed {
    logic [SrttW-1:0] srtt;
    logic [DevW-1:0]  mdev;
    logic [DevW-1:0]  dev_max;
    logic [DevW-1:0]  var_hold;
  } rre_state_t;

  typedef struct packed {
    logic [RtoW-1:0]  rto;
    logic [SrttW-1:0] srtt;
    logic [DevW-1:0]  rttvar;
  } rre_result_t;

endpackage

// File: rtl/rre_if.sv
// ----------------------------------------------------------------------------
// rre_if
// Valid / ready channels for RTT samples and estimator results.
// ----------------------------------------------------------------------------
interface rre_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] rtt_sample;

  modport source (output valid, output rtt_sample, input ready);
  modport sink   (input valid, input rtt_sample, output ready);
endinterface

interface rre_result_if;
  logic        valid;
  logic        ready;
  logic [21:0] rto;
  logic [19:0] smoothed_rtt;
  logic [20:0] rtt_variance;

  modport source (output valid, output rto, output smoothed_rtt, output rtt_variance,
                  input ready);
  modport sink   (input valid, input rto, input smoothed_rtt, input rtt_variance,
                  output ready);
endinterface

// File: rtl/rre_update.sv
// ----------------------------------------------------------------------------
// rre_update
// Single-pass estimator update: first-sample initialisation or the
// integer smoothed RTT / mean deviation update, plus the saturating RTO.
// ----------------------------------------------------------------------------
module rre_update import rre_pkg::*; (
  input  rre_state_t         state_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic [SampleW-1:0] min_rto_i,
  output rre_state_t         state_o,
  output rre_result_t        result_o
);

  logic [SampleW-1:0] m;
  logic               first;
  logic signed [17:0] err;
  logic signed [21:0] s;
  logic signed [23:0] neg_gap;
  logic signed [23:0] pos_gap;
  logic signed [23:0] adj;
  logic signed [23:0] d;
  logic [SrttW-1:0]   srtt_upd;
  logic [DevW-1:0]    mdev_upd;
  logic [SrttW-1:0]   srtt_init;
  logic [DevW-1:0]    mdev_init;
  logic [DevW-1:0]    floor_init;
  logic [23:0]        total;

  assign m     = (sample_i == '0) ? 16'd1 : sample_i;
  assign first = (state_i.srtt == '0);

  assign err = $signed({2'b00, m}) - $signed({1'b0, state_i.srtt[SrttW-1:3]});
  assign s   = $signed({2'b00, state_i.srtt}) + $signed({{4{err[17]}}, err});
  assign srtt_upd = s[21] ? '0 : s[SrttW-1:0];

  // gap between absolute error and a quarter of the mean deviation
  assign neg_gap = $signed(24'd0) - $signed({{6{err[17]}}, err})
                   - $signed({5'b00000, state_i.mdev[DevW-1:2]});
  assign pos_gap = $signed({{6{err[17]}}, err})
                   - $signed({5'b00000, state_i.mdev[DevW-1:2]});

  always_comb begin
    if (err[17]) begin
      if (!neg_gap[23] && (neg_gap != '0)) begin
        adj = $signed({3'b000, neg_gap[23:3]});
      end else begin
        adj = neg_gap;
      end
    end else begin
      adj = pos_gap;
    end
  end

  assign d        = $signed({3'b000, state_i.mdev}) + adj;
  assign mdev_upd = d[23] ? '0 : d[DevW-1:0];

  assign srtt_init  = {1'b0, m, 3'b000};
  assign mdev_init  = {4'b0000, m, 1'b0};
  assign floor_init = (mdev_init > {5'b00000, min_rto_i}) ? mdev_init
                                                          : {5'b00000, min_rto_i};

  always_comb begin
    state_o = state_i;
    if (first) begin
      state_o.srtt     = srtt_init;
      state_o.mdev     = mdev_init;
      state_o.dev_max  = floor_init;
      state_o.var_hold = floor_init;
    end else begin
      state_o.srtt = srtt_upd;
      state_o.mdev = mdev_upd;
      if (mdev_upd > state_i.dev_max) begin
        state_o.dev_max = mdev_upd;
        if (mdev_upd > state_i.var_hold) begin
          state_o.var_hold = mdev_upd;
        end
      end
    end
  end

  assign total = {4'b0000, state_o.srtt} + {1'b0, state_o.mdev, 2'b00};

  assign result_o.rto    = (total[23:22] != 2'b00) ? '1 : total[RtoW-1:0];
  assign result_o.srtt   = state_o.srtt;
  assign result_o.rttvar = state_o.var_hold;

endmodule

// File: rtl/rtt_rto_estimator.sv
// ----------------------------------------------------------------------------
// rtt_rto_estimator
// Jacobson/Karels style round-trip estimator producing srtt, rttvar and a
// saturating retransmit timeout for every RTT sample beat.
// ----------------------------------------------------------------------------
//  channel     dir  payload                                  width
//  sample_i    in   rtt_sample                               16
//  result_o    out  rto, smoothed_rtt, rtt_variance          22, 20, 21
//  cfg_*       in   min_rto (write only)                     16
//
//  one beat per clock sustained while result_o is ready; sample register
//  then result register, with the estimator state updated as a beat moves
//  between them. a stalled result holds a full sample stage and the result
//  stage; the sample stage still takes a beat while the result stage drains.
//  reset clears the state (no sample yet) and sets min_rto to 200.
// ----------------------------------------------------------------------------
module rtt_rto_estimator import rre_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SampleW-1:0] cfg_wdata_i,
  rre_sample_if.sink         sample_i,
  rre_result_if.source       result_o
);

  logic               in_v_q;
  logic [SampleW-1:0] sample_q;
  logic               out_v_q;
  rre_result_t        res_q;
  rre_state_t         state_q;
  rre_state_t         state_d;
  rre_result_t        res_d;
  logic [SampleW-1:0] min_rto_q;
  logic               out_free;
  logic               advance;

  assign out_free        = !out_v_q || result_o.ready;
  assign advance         = in_v_q && out_free;
  assign sample_i.ready  = !in_v_q || out_free;

  rre_update u_update (
    .state_i   (state_q),
    .sample_i  (sample_q),
    .min_rto_i (min_rto_q),
    .state_o   (state_d),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rto_q <= MinRtoReset;
    end else if (cfg_we_i) begin
      min_rto_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      state_q <= '0;
    end else begin
      if (sample_i.ready) begin
        in_v_q <= sample_i.valid;
      end
      if (out_free) begin
        out_v_q <= in_v_q;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (sample_i.ready && sample_i.valid) begin
      sample_q <= sample_i.rtt_sample;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid        = out_v_q;
  assign result_o.rto          = res_q.rto;
  assign result_o.smoothed_rtt = res_q.srtt;
  assign result_o.rtt_variance = res_q.rttvar;

endmodule
